// ----- hdl/smdme_pkg.sv -----
// smdme_pkg: shared types and codes for the signed arithmetic unit
// no dependencies
`default_nettype none
package smdme_pkg;
  typedef enum logic [2:0] {
    MODE_ADD = 3'd0, MODE_SUB = 3'd1, MODE_MUL = 3'd2,
    MODE_DIV = 3'd3, MODE_POW = 3'd4, MODE_MPOW = 3'd5
  } mode_e;

  typedef enum logic [1:0] {
    ST_OK = 2'd0, ST_OVF = 2'd1, ST_ZERO = 2'd2, ST_NEGEXP = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE, S_ADD, S_DIV, S_MUL, S_PMUL, S_PSQR, S_MRED, S_MMUL, S_MSQR,
    S_DONE
  } state_e;
endpackage
`default_nettype wire

// ----- hdl/smdme_serial.sv -----
// smdme_serial: bit-serial shift-add (mod n) multiplier / shift-subtract divider
// depends on no other file; one bit of x per cycle
`default_nettype none
module smdme_serial #(
  parameter int N = 64
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         go_i,
  input  wire logic         div_i,   // 1: divide x by y, 0: x*y (mod n when mod_i)
  input  wire logic         mod_i,
  input  wire logic [N-1:0] x_i,
  input  wire logic [N-1:0] y_i,
  input  wire logic [N-1:0] n_i,
  output logic              done_o,
  output logic [N-1:0]      hi_o,    // product high or remainder or mulmod
  output logic [N-1:0]      lo_o     // product low or quotient
);
  localparam int CW = $clog2(N + 1);
  logic [N-1:0] x_q, x_d, y_q, y_d, n_q, n_d, hi_q, hi_d, lo_q, lo_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic run_q, run_d, div_q, div_d, mod_q, mod_d, done_q, done_d;
  logic [N:0] sh, s1, t;

  always_comb begin
    x_d = x_q; y_d = y_q; n_d = n_q; hi_d = hi_q; lo_d = lo_q;
    cnt_d = cnt_q; run_d = run_q; div_d = div_q; mod_d = mod_q; done_d = 1'b0;
    sh = '0; s1 = '0; t = '0;
    if (go_i) begin
      x_d = x_i; y_d = y_i; n_d = n_i; hi_d = '0; lo_d = '0;
      cnt_d = CW'(N); run_d = 1'b1; div_d = div_i; mod_d = mod_i;
    end else if (run_q) begin
      if (div_q) begin
        // restoring division, quotient bits into lo
        sh = {hi_q, x_q[N-1]};
        t = sh - {1'b0, y_q};
        x_d = {x_q[N-2:0], 1'b0};
        if (!t[N]) begin
          hi_d = t[N-1:0]; lo_d = {lo_q[N-2:0], 1'b1};
        end else begin
          hi_d = sh[N-1:0]; lo_d = {lo_q[N-2:0], 1'b0};
        end
      end else if (mod_q) begin
        // interleaved modular multiply, msb first
        sh = {hi_q, 1'b0};
        if (sh >= {1'b0, n_q}) sh = sh - {1'b0, n_q};
        s1 = sh + (x_q[N-1] ? {1'b0, y_q} : '0);
        if (s1 >= {1'b0, n_q}) s1 = s1 - {1'b0, n_q};
        hi_d = s1[N-1:0];
        x_d = {x_q[N-2:0], 1'b0};
      end else begin
        // lsb-first shift-add, 2N-bit product in hi:lo
        s1 = {1'b0, hi_q} + (x_q[0] ? {1'b0, y_q} : '0);
        hi_d = s1[N:1];
        lo_d = {s1[0], lo_q[N-1:1]};
        x_d = {1'b0, x_q[N-1:1]};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CW'(1)) begin
        run_d = 1'b0; done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q <= 1'b0; done_q <= 1'b0; cnt_q <= '0; div_q <= 1'b0; mod_q <= 1'b0;
    end else begin
      run_q <= run_d; done_q <= done_d; cnt_q <= cnt_d; div_q <= div_d;
      mod_q <= mod_d;
    end
  end
  always_ff @(posedge clk_i) begin
    x_q <= x_d; y_q <= y_d; n_q <= n_d; hi_q <= hi_d; lo_q <= lo_d;
  end

  assign done_o = done_q;
  assign hi_o = hi_q;
  assign lo_o = lo_q;

  a_done_after_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !run_q) else $error("serial done while running");
  a_cnt_zero_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (run_q && !go_i) |-> cnt_q != '0) else $error("serial count underflow");
  a_go_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    go_i |=> run_q) else $error("serial did not start");
endmodule
`default_nettype wire

// ----- hdl/signed_muldiv_modexp_unit.sv -----
// signed_muldiv_modexp_unit: top level, sequencer around one serial mul/div unit
// depends on smdme_pkg and smdme_serial
//
// channel   direction  handshake           payload
// request   in         start & !busy       mode_i operand_a_i operand_b_i modulus_i
// result    out        done_o (one cycle)  result_value_o remainder_value_o status_o
//
// add/sub finish in the sequencer; mul and divide run the serial unit once; power
// multiplies per set exponent bit and squares while bits remain; modular power
// reduces, then mulmods per set bit and squares per bit; EW = min(WIDTH, 64)
// reset clears the sequencer and strobe; busy is high from accept until done
// the receiver cannot stall: done_o marks the result for exactly one cycle
`default_nettype none
module signed_muldiv_modexp_unit #(
  parameter int WIDTH = 64
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [2:0]  mode_i,
  input  wire logic signed [63:0] operand_a_i,
  input  wire logic signed [63:0] operand_b_i,
  input  wire logic signed [63:0] modulus_i,
  output logic             done_o,
  output logic signed [63:0] result_value_o,
  output logic signed [63:0] remainder_value_o,
  output logic [1:0]       status_o
);
  localparam int EW = (WIDTH < 64) ? WIDTH : 64;

  smdme_pkg::state_e st_q, st_d;
  logic [EW-1:0] a_q, a_d, b_q, b_d, c_q, c_d, t_q, t_d, base_q, base_d;
  logic [EW-1:0] res_q, res_d, rem_q, rem_d, n_q, n_d;
  logic i_q, i_d;
  logic ovf_q, ovf_d, aneg_q, aneg_d, neg_q, neg_d;
  logic [2:0] mode_q, mode_d;
  logic [1:0] stat_q, stat_d;
  logic done_q, done_d;

  // serial unit controls
  logic go, sdiv, smod, sdone;
  logic [EW-1:0] sx, sy, sn, shi, slo;

  smdme_serial #(.N(EW)) u_serial (
    .clk_i, .rst_ni, .go_i(go), .div_i(sdiv), .mod_i(smod),
    .x_i(sx), .y_i(sy), .n_i(sn), .done_o(sdone), .hi_o(shi), .lo_o(slo)
  );

  function automatic logic [EW-1:0] magf(input logic [EW-1:0] v);
    magf = v[EW-1] ? EW'(-v) : v;
  endfunction

  // add/sub
  logic [EW-1:0] sum;
  logic sum_ovf;
  always_comb begin
    if (mode_q == smdme_pkg::MODE_SUB) begin
      sum = a_q - b_q;
      sum_ovf = (a_q[EW-1] ^ b_q[EW-1]) & (a_q[EW-1] ^ sum[EW-1]);
    end else begin
      sum = a_q + b_q;
      sum_ovf = (a_q[EW-1] ^ sum[EW-1]) & (b_q[EW-1] ^ sum[EW-1]);
    end
  end

  // signed result of a magnitude product in shi:slo
  logic [EW-1:0] prod;
  logic prod_ovf;
  logic [EW-1:0] lim;
  always_comb begin
    lim = {1'b0, {(EW-1){1'b1}}} + EW'(neg_q);
    prod = neg_q ? EW'(-slo) : slo;
    prod_ovf = (shi != '0) || (slo > lim);
  end

  // more exponent bits remain above the lsb
  logic bmore;
  assign bmore = (b_q >> 1) != '0;

  always_comb begin
    st_d = st_q; a_d = a_q; b_d = b_q; c_d = c_q; t_d = t_q; base_d = base_q;
    res_d = res_q; rem_d = rem_q; n_d = n_q; i_d = i_q; ovf_d = ovf_q;
    aneg_d = aneg_q; neg_d = neg_q; mode_d = mode_q; stat_d = stat_q;
    done_d = 1'b0;
    go = 1'b0; sdiv = 1'b0; smod = 1'b0; sx = '0; sy = '0; sn = n_q;
    case (st_q)
      smdme_pkg::S_IDLE: begin
        if (start && !busy) begin
          a_d = operand_a_i[EW-1:0]; b_d = operand_b_i[EW-1:0];
          c_d = modulus_i[EW-1:0]; mode_d = mode_i;
          res_d = '0; rem_d = '0; ovf_d = 1'b0; stat_d = smdme_pkg::ST_OK;
          st_d = smdme_pkg::S_ADD;
        end
      end
      smdme_pkg::S_ADD: begin
        // dispatch
        aneg_d = a_q[EW-1];
        case (mode_q)
          smdme_pkg::MODE_ADD, smdme_pkg::MODE_SUB: begin
            res_d = sum; ovf_d = sum_ovf; st_d = smdme_pkg::S_DONE;
          end
          smdme_pkg::MODE_MUL: begin
            go = 1'b1; sx = magf(a_q); sy = magf(b_q);
            neg_d = a_q[EW-1] ^ b_q[EW-1]; st_d = smdme_pkg::S_MUL;
          end
          smdme_pkg::MODE_DIV: begin
            if (b_q == '0) begin
              stat_d = smdme_pkg::ST_ZERO; st_d = smdme_pkg::S_DONE;
            end else begin
              go = 1'b1; sdiv = 1'b1; sx = magf(a_q); sy = magf(b_q);
              neg_d = a_q[EW-1] ^ b_q[EW-1]; st_d = smdme_pkg::S_DIV;
            end
          end
          smdme_pkg::MODE_POW: begin
            if (b_q[EW-1]) begin
              stat_d = smdme_pkg::ST_NEGEXP; st_d = smdme_pkg::S_DONE;
            end else begin
              t_d = EW'(1); base_d = a_q; st_d = smdme_pkg::S_PMUL;
            end
          end
          smdme_pkg::MODE_MPOW: begin
            if (c_q == '0) begin
              stat_d = smdme_pkg::ST_ZERO; st_d = smdme_pkg::S_DONE;
            end else if (b_q[EW-1]) begin
              stat_d = smdme_pkg::ST_NEGEXP; st_d = smdme_pkg::S_DONE;
            end else begin
              // base = |a| mod n via divider
              n_d = magf(c_q);
              go = 1'b1; sdiv = 1'b1; sx = magf(a_q); sy = magf(c_q);
              st_d = smdme_pkg::S_MRED;
            end
          end
          default: st_d = smdme_pkg::S_DONE;
        endcase
      end
      smdme_pkg::S_MUL: begin
        if (sdone) begin
          res_d = prod; ovf_d = prod_ovf; st_d = smdme_pkg::S_DONE;
        end
      end
      smdme_pkg::S_DIV: begin
        if (sdone) begin
          res_d = neg_q ? EW'(-slo) : slo;
          rem_d = aneg_q ? EW'(-shi) : shi;
          ovf_d = !neg_q && slo[EW-1];
          st_d = smdme_pkg::S_DONE;
        end
      end
      // power: t *= base when bit set, then square while bits remain
      smdme_pkg::S_PMUL: begin
        if (b_q == '0) begin
          res_d = t_q; st_d = smdme_pkg::S_DONE;
        end else if (!i_q) begin
          if (b_q[0]) begin
            go = 1'b1; sx = magf(t_q); sy = magf(base_q);
            neg_d = t_q[EW-1] ^ base_q[EW-1]; i_d = 1'b1;
          end else begin
            st_d = smdme_pkg::S_PSQR; i_d = 1'b0;
          end
        end else if (sdone) begin
          t_d = prod; ovf_d = ovf_q | prod_ovf;
          st_d = smdme_pkg::S_PSQR; i_d = 1'b0;
        end
      end
      smdme_pkg::S_PSQR: begin
        if (!bmore) begin
          res_d = t_q; st_d = smdme_pkg::S_DONE;
        end else if (!i_q) begin
          go = 1'b1; sx = magf(base_q); sy = magf(base_q);
          neg_d = 1'b0; i_d = 1'b1;
        end else if (sdone) begin
          base_d = prod; ovf_d = ovf_q | prod_ovf;
          b_d = b_q >> 1; i_d = 1'b0; st_d = smdme_pkg::S_PMUL;
        end
      end
      smdme_pkg::S_MRED: begin
        if (sdone) begin
          base_d = shi;
          // 1 mod n
          t_d = (n_q == EW'(1)) ? '0 : EW'(1);
          i_d = 1'b0; st_d = smdme_pkg::S_MMUL;
        end
      end
      smdme_pkg::S_MMUL: begin
        if (b_q == '0) begin
          res_d = (aneg_q && c_q[0] && t_q != '0) ? EW'(-t_q) : t_q;
          st_d = smdme_pkg::S_DONE;
        end else if (!i_q) begin
          if (b_q[0]) begin
            go = 1'b1; smod = 1'b1; sx = t_q; sy = base_q; i_d = 1'b1;
          end else begin
            st_d = smdme_pkg::S_MSQR;
          end
        end else if (sdone) begin
          t_d = shi; i_d = 1'b0; st_d = smdme_pkg::S_MSQR;
        end
      end
      smdme_pkg::S_MSQR: begin
        if (!i_q) begin
          go = 1'b1; smod = 1'b1; sx = base_q; sy = base_q; i_d = 1'b1;
        end else if (sdone) begin
          base_d = shi; b_d = b_q >> 1; i_d = 1'b0; st_d = smdme_pkg::S_MMUL;
        end
      end
      smdme_pkg::S_DONE: begin
        done_d = 1'b1;
        if (stat_q == smdme_pkg::ST_OK && ovf_q) stat_d = smdme_pkg::ST_OVF;
        st_d = smdme_pkg::S_IDLE;
      end
      default: st_d = smdme_pkg::S_IDLE;
    endcase
    // c_q keeps the original exponent lsb for the sign fix in modular power
    if (st_q == smdme_pkg::S_ADD && mode_q == smdme_pkg::MODE_MPOW) c_d = EW'(b_q[0]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= smdme_pkg::S_IDLE; done_q <= 1'b0; i_q <= 1'b0;
    end else begin
      st_q <= st_d; done_q <= done_d; i_q <= i_d;
    end
  end
  always_ff @(posedge clk_i) begin
    a_q <= a_d; b_q <= b_d; c_q <= c_d; t_q <= t_d; base_q <= base_d;
    res_q <= res_d; rem_q <= rem_d; n_q <= n_d; ovf_q <= ovf_d;
    aneg_q <= aneg_d; neg_q <= neg_d; mode_q <= mode_d; stat_q <= stat_d;
  end

  assign busy = (st_q != smdme_pkg::S_IDLE) || done_q;
  assign done_o = done_q;
  assign result_value_o = 64'(signed'(res_q));
  assign remainder_value_o = 64'(signed'(rem_q));
  assign status_o = stat_q;

  a_done_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |=> !done_q) else $error("done held two cycles");
  a_busy_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> busy) else $error("result while not busy");
  a_ok_zero_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_q && mode_q != smdme_pkg::MODE_DIV) |-> rem_q == '0)
    else $error("remainder outside divide");
endmodule
`default_nettype wire
